/* rtl/core/assert_macros.svh */
// shared assertion macros
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked on every clock edge outside reset
`define CHK_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("check failed");

// next-cycle implication checked outside reset
`define CHK_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("check failed");

`endif

/* rtl/core/efc_pkg.sv */
`default_nettype none
package efc_pkg;
    localparam int unsigned POS_W = 32;
    localparam int unsigned VEC_W = 16;
    localparam int unsigned YAW_W = 21;
    localparam int unsigned PIT_W = 20;
    localparam int unsigned ANG_W = 27;
    localparam int unsigned CRD_W = 34;
    localparam int unsigned ATAN_COUNT = 24;

    localparam logic [YAW_W-1:0] YAW_FULL = 21'd1474560;
    localparam logic [YAW_W-1:0] YAW_RESET = 21'd245760;
    localparam int signed YAW_HALF = 737280;
    localparam int signed QUARTER = 368640;
    localparam int signed PITCH_LIM = 364544;
    localparam logic signed [CRD_W-1:0] GAIN_Q30 = 34'sd652032874;
    localparam logic signed [VEC_W-1:0] Q14_ONE = 16'sd16384;

    localparam logic ACT_MOVE = 1'b0;
    localparam logic ACT_TURN = 1'b1;

    localparam logic [2:0] DIR_FWD = 3'd0;
    localparam logic [2:0] DIR_DOWN = 3'd5;

    typedef logic signed [VEC_W-1:0] vec_t;
    typedef logic signed [POS_W-1:0] pos_t;

    function automatic logic signed [ANG_W-1:0] atan_deg(input logic [4:0] i);
        logic signed [ANG_W-1:0] r;
        begin
            case (i)
                5'd0: r = 27'sd2949120;
                5'd1: r = 27'sd1740967;
                5'd2: r = 27'sd919879;
                5'd3: r = 27'sd466945;
                5'd4: r = 27'sd234379;
                5'd5: r = 27'sd117304;
                5'd6: r = 27'sd58666;
                5'd7: r = 27'sd29335;
                5'd8: r = 27'sd14668;
                5'd9: r = 27'sd7334;
                5'd10: r = 27'sd3667;
                5'd11: r = 27'sd1833;
                5'd12: r = 27'sd917;
                5'd13: r = 27'sd458;
                5'd14: r = 27'sd229;
                5'd15: r = 27'sd115;
                5'd16: r = 27'sd57;
                5'd17: r = 27'sd29;
                5'd18: r = 27'sd14;
                5'd19: r = 27'sd7;
                5'd20: r = 27'sd4;
                5'd21: r = 27'sd2;
                5'd22: r = 27'sd1;
                default: r = '0;
            endcase
            return r;
        end
    endfunction
endpackage
`default_nettype wire

/* rtl/core/efc_mul.sv */
`default_nettype none
// shift-and-add signed multiplier, one multiplier bit per cycle
module efc_mul
    import efc_pkg::*;
#(
    parameter int unsigned AW = 34,
    parameter int unsigned BW = 34
)
(
    input  wire                       clk,
    input  wire                       rst_n,
    input  wire                       start,
    input  wire  signed [AW-1:0]      a,
    input  wire  signed [BW-1:0]      b,
    output logic                      done,
    output logic signed [AW+BW-1:0]   prod
);
    localparam int unsigned CW = $clog2(BW + 1);
    logic [CW-1:0] cnt_reg;
    logic busy_reg;
    logic signed [AW+BW-1:0] acc_reg;
    logic signed [AW+BW-1:0] mcand_reg;
    logic [BW-1:0] mplier_reg;
    logic signed [AW+BW-1:0] addend;

    // top multiplier bit has negative weight
    always_comb
    begin
        if (!mplier_reg[0])
            addend = '0;
        else if (cnt_reg == CW'(BW - 1))
            addend = -mcand_reg;
        else
            addend = mcand_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg <= '0;
            done <= 1'b0;
        end
        else
        begin
            done <= busy_reg && !start && (cnt_reg == CW'(BW - 1));
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CW'(BW - 1))
                    busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            acc_reg <= '0;
            mcand_reg <= (AW+BW)'(a);
            mplier_reg <= b;
        end
        else if (busy_reg)
        begin
            acc_reg <= acc_reg + addend;
            mcand_reg <= mcand_reg <<< 1;
            mplier_reg <= mplier_reg >> 1;
        end
    end

    assign prod = acc_reg;
endmodule
`default_nettype wire

/* rtl/core/euler_fly_camera_update_top.sv */
`default_nettype none
// Fly camera block: keeps position (Q16.16), yaw/pitch (degrees Q.12) and the
// front/side/head basis (Q2.14). The action flag travels on s_tuser. Every
// multiply goes through one 34-bit shift-and-add multiplier, one bit a cycle.
// A turn item takes two multiplies for the angle update, a yaw reduction,
// two CORDIC passes and four basis multiplies. A move item takes one velocity
// multiply and three component multiplies; an undefined direction goes straight
// to output. One item is in work at a time; the result waits in an output
// register while the next item is taken and worked on. After reset the block
// first builds the initial basis before it accepts an item.
module euler_fly_camera_update_top
    import efc_pkg::*;
#(
    parameter int unsigned TRIG_STEPS = 16
)
(
    input  wire          clk,
    input  wire          rst_n,
    input  wire          cfg_we,
    input  wire  [0:0]   cfg_index,
    input  wire  [15:0]  cfg_data,
    input  wire          s_tvalid,
    output logic         s_tready,
    // move_dir, time_step, pointer_dx, pointer_dy
    input  wire  [55:0]  s_tdata,
    // action
    input  wire  [0:0]   s_tuser,
    output logic         m_tvalid,
    input  wire          m_tready,
    // pos_x, pos_y, pos_z, front_x..z, side_x..z, head_x..z
    output logic [239:0] m_tdata
);
    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_SENS = 4'd1;
    localparam logic [3:0] ST_ANG = 4'd2;
    localparam logic [3:0] ST_CORD = 4'd3;
    localparam logic [3:0] ST_BAS = 4'd4;
    localparam logic [3:0] ST_VEL = 4'd5;
    localparam logic [3:0] ST_STEP = 4'd6;
    localparam logic [3:0] ST_OUT = 4'd7;
    localparam int unsigned SW = $clog2(TRIG_STEPS + 1);
    localparam int unsigned NSTEP = (TRIG_STEPS < ATAN_COUNT) ? TRIG_STEPS : ATAN_COUNT;

    logic [3:0] st_reg;
    logic [15:0] speed_reg, sens_reg;
    pos_t pos_reg [3];
    logic [YAW_W-1:0] yaw_reg;
    logic signed [PIT_W-1:0] pitch_reg;
    vec_t bas_reg [9];
    logic [2:0] dir_reg;
    logic [15:0] ts_reg;
    logic signed [15:0] dx_reg, dy_reg;
    logic [3:0] sub_reg;
    logic [SW-1:0] it_reg;
    logic signed [CRD_W-1:0] cx_reg, cy_reg, cy_c_reg, sy_c_reg, cp_c_reg, sp_c_reg;
    logic signed [ANG_W-1:0] z_reg;
    logic flip_reg, which_reg, mul_go_reg, in_item_reg;
    logic mul_go_next;
    logic out_load;
    logic signed [47:0] dxs_reg;
    logic signed [35:0] vel_reg;
    logic out_full_reg;
    logic [239:0] out_reg;

    logic signed [CRD_W-1:0] ma, mb;
    logic signed [2*CRD_W-1:0] mp;
    logic mdone;

    efc_mul #(.AW(CRD_W), .BW(CRD_W)) u_mul (
        .clk(clk), .rst_n(rst_n), .start(mul_go_reg), .a(ma), .b(mb),
        .done(mdone), .prod(mp)
    );

    function automatic logic signed [CRD_W-1:0] fshift(input logic signed [CRD_W-1:0] v,
                                                     input logic [SW-1:0] s);
        return v >>> s;
    endfunction

    function automatic vec_t rq14(input logic signed [2*CRD_W-1:0] v, input int unsigned s);
        logic signed [2*CRD_W-1:0] r;
        begin
            r = (v + ((2*CRD_W)'(1) <<< (s - 1))) >>> s;
            if (r > (2*CRD_W)'(16384))
                r = (2*CRD_W)'(16384);
            if (r < -(2*CRD_W)'(16384))
                r = -(2*CRD_W)'(16384);
            return VEC_W'(r);
        end
    endfunction

    // angle folding before rotation
    logic signed [ANG_W-1:0] a_in, a_f;
    logic flip_c;
    always_comb
    begin
        if (which_reg)
            a_in = ANG_W'(pitch_reg);
        else
            a_in = ANG_W'($signed({1'b0, yaw_reg}));
        if (a_in > ANG_W'(YAW_HALF))
            a_in = a_in - ANG_W'($signed({1'b0, YAW_FULL}));
        flip_c = 1'b0;
        a_f = a_in;
        if (a_in > ANG_W'(QUARTER))
        begin
            a_f = a_in - ANG_W'(YAW_HALF);
            flip_c = 1'b1;
        end
        else if (a_in < -ANG_W'(QUARTER))
        begin
            a_f = a_in + ANG_W'(YAW_HALF);
            flip_c = 1'b1;
        end
    end

    // multiplier operand select
    always_comb
    begin
        ma = '0;
        mb = '0;
        case (st_reg)
            ST_SENS:
            begin
                ma = sub_reg[0] ? CRD_W'(dy_reg) : CRD_W'(dx_reg);
                mb = CRD_W'({1'b0, sens_reg});
            end
            ST_BAS:
            begin
                ma = sub_reg[1] ? sp_c_reg : cp_c_reg;
                mb = sub_reg[0] ? sy_c_reg : cy_c_reg;
            end
            ST_VEL:
            begin
                ma = CRD_W'({1'b0, speed_reg});
                mb = CRD_W'({1'b0, ts_reg});
            end
            ST_STEP:
            begin
                ma = CRD_W'(bas_reg[{1'b0, dir_reg[2:1], 1'b0} + {2'b00, dir_reg[2:1]}
                                    + {2'b00, sub_reg[1:0]}]);
                mb = CRD_W'(vel_reg);
            end
            default: ;
        endcase
    end

    // multiplier start for the next cycle
    always_comb
    begin
        case (st_reg)
            ST_IDLE:
                mul_go_next = s_tvalid && s_tready
                              && (s_tuser[0] == ACT_TURN || s_tdata[2:0] <= DIR_DOWN);
            ST_SENS: mul_go_next = mdone && !sub_reg[0];
            ST_CORD: mul_go_next = (it_reg == SW'(NSTEP)) && which_reg;
            ST_BAS: mul_go_next = mdone && (sub_reg[1:0] != 2'd3);
            ST_VEL: mul_go_next = mdone;
            ST_STEP: mul_go_next = mdone && (sub_reg[1:0] != 2'd2);
            default: mul_go_next = 1'b0;
        endcase
    end

    logic signed [48:0] yw_t;
    logic signed [48:0] pt_t;
    logic signed [2*CRD_W-1:0] stp;
    logic signed [33:0] psum;
    logic [1:0] k;
    always_comb
    begin
        k = sub_reg[1:0];
        stp = (dir_reg[0] ? -mp : mp) + (2*CRD_W)'(1 <<< 21);
        stp = stp >>> 22;
        psum = 34'(pos_reg[k]) + 34'(stp);
        if (psum > 34'sd2147483647)
            psum = 34'sd2147483647;
        if (psum < -34'sd2147483648)
            psum = -34'sd2147483648;
        yw_t = 49'($signed({1'b0, yaw_reg})) + 49'(dxs_reg);
        pt_t = 49'(pitch_reg) + 49'(mp);
        if (pt_t > 49'(PITCH_LIM))
            pt_t = 49'(PITCH_LIM);
        if (pt_t < -49'(PITCH_LIM))
            pt_t = -49'(PITCH_LIM);
    end

    // yaw reduction by repeated subtraction or addition of shifted multiples of 360 degrees
    logic signed [48:0] ymod_reg;
    logic [4:0] yk_reg;

    assign s_tready = (st_reg == ST_IDLE) && !in_item_reg;
    assign m_tvalid = out_full_reg;
    assign m_tdata = out_reg;
    assign out_load = (st_reg == ST_OUT) && in_item_reg && (!out_full_reg || m_tready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= ST_ANG;
            speed_reg <= 16'd256;
            sens_reg <= 16'd1229;
            pos_reg[0] <= '0;
            pos_reg[1] <= '0;
            pos_reg[2] <= '0;
            yaw_reg <= YAW_RESET;
            pitch_reg <= '0;
            sub_reg <= '0;
            it_reg <= '0;
            which_reg <= 1'b0;
            mul_go_reg <= 1'b0;
            in_item_reg <= 1'b0;
            out_full_reg <= 1'b0;
            yk_reg <= '0;
        end
        else
        begin
            mul_go_reg <= mul_go_next;
            if (cfg_we)
            begin
                if (cfg_index == 1'b0)
                    speed_reg <= cfg_data;
                else
                    sens_reg <= cfg_data;
            end
            if (out_load)
                out_full_reg <= 1'b1;
            else if (m_tready)
                out_full_reg <= 1'b0;
            case (st_reg)
                ST_IDLE:
                begin
                    if (s_tvalid && s_tready)
                    begin
                        in_item_reg <= 1'b1;
                        dir_reg <= s_tdata[2:0];
                        ts_reg <= s_tdata[18:3];
                        dx_reg <= s_tdata[34:19];
                        dy_reg <= s_tdata[50:35];
                        sub_reg <= '0;
                        if (s_tuser[0] == ACT_TURN)
                            st_reg <= ST_SENS;
                        else if (s_tdata[2:0] > DIR_DOWN)
                            st_reg <= ST_OUT;
                        else
                            st_reg <= ST_VEL;
                    end
                end
                ST_SENS:
                begin
                    if (mdone)
                    begin
                        if (sub_reg[0] == 1'b0)
                        begin
                            // dx*sens stored negated: added to yaw later
                            dxs_reg <= -48'(mp);
                            sub_reg <= 4'd1;
                        end
                        else
                        begin
                            pitch_reg <= PIT_W'(pt_t);
                            ymod_reg <= yw_t;
                            yk_reg <= 5'd20;
                            sub_reg <= 4'd2;
                        end
                    end
                    else if (sub_reg == 4'd2)
                    begin
                        // one restoring step per cycle toward [0, 360)
                        if (ymod_reg < 0)
                            ymod_reg <= ymod_reg + (49'($signed({1'b0, YAW_FULL})) <<< yk_reg);
                        else if (ymod_reg >= (49'($signed({1'b0, YAW_FULL})) <<< yk_reg))
                            ymod_reg <= ymod_reg - (49'($signed({1'b0, YAW_FULL})) <<< yk_reg);
                        else if (yk_reg != 5'd0)
                            yk_reg <= yk_reg - 1'b1;
                        else
                        begin
                            yaw_reg <= YAW_W'(ymod_reg);
                            which_reg <= 1'b0;
                            sub_reg <= '0;
                            st_reg <= ST_ANG;
                        end
                    end
                end
                ST_ANG:
                begin
                    cx_reg <= GAIN_Q30;
                    cy_reg <= '0;
                    z_reg <= a_f <<< 4;
                    flip_reg <= flip_c;
                    it_reg <= '0;
                    st_reg <= ST_CORD;
                end
                ST_CORD:
                begin
                    if (it_reg == SW'(NSTEP))
                    begin
                        if (!which_reg)
                        begin
                            cy_c_reg <= flip_reg ? -cx_reg : cx_reg;
                            sy_c_reg <= flip_reg ? -cy_reg : cy_reg;
                            which_reg <= 1'b1;
                            st_reg <= ST_ANG;
                        end
                        else
                        begin
                            cp_c_reg <= flip_reg ? -cx_reg : cx_reg;
                            sp_c_reg <= flip_reg ? -cy_reg : cy_reg;
                            sub_reg <= '0;
                            st_reg <= ST_BAS;
                        end
                    end
                    else
                    begin
                        it_reg <= it_reg + 1'b1;
                        if (z_reg >= 0)
                        begin
                            cx_reg <= cx_reg - fshift(cy_reg, it_reg);
                            cy_reg <= cy_reg + fshift(cx_reg, it_reg);
                            z_reg <= z_reg - atan_deg(5'(it_reg));
                        end
                        else
                        begin
                            cx_reg <= cx_reg + fshift(cy_reg, it_reg);
                            cy_reg <= cy_reg - fshift(cx_reg, it_reg);
                            z_reg <= z_reg + atan_deg(5'(it_reg));
                        end
                    end
                end
                ST_BAS:
                begin
                    if (mdone)
                    begin
                        case (sub_reg[1:0])
                            2'd0: bas_reg[0] <= rq14(mp, 46);
                            2'd1: bas_reg[1] <= rq14(mp, 46);
                            2'd2: bas_reg[6] <= rq14(-mp, 46);
                            default: bas_reg[7] <= rq14(-mp, 46);
                        endcase
                        if (sub_reg[1:0] == 2'd3)
                        begin
                            bas_reg[2] <= rq14((2*CRD_W)'(sp_c_reg), 16);
                            bas_reg[3] <= rq14((2*CRD_W)'(sy_c_reg), 16);
                            bas_reg[4] <= rq14(-(2*CRD_W)'(cy_c_reg), 16);
                            bas_reg[5] <= '0;
                            bas_reg[8] <= rq14((2*CRD_W)'(cp_c_reg), 16);
                            st_reg <= ST_OUT;
                        end
                        else
                            sub_reg <= sub_reg + 1'b1;
                    end
                end
                ST_VEL:
                begin
                    if (mdone)
                    begin
                        vel_reg <= 36'(mp);
                        sub_reg <= '0;
                        st_reg <= ST_STEP;
                    end
                end
                ST_STEP:
                begin
                    if (mdone)
                    begin
                        pos_reg[k] <= POS_W'(psum);
                        if (k == 2'd2)
                            st_reg <= ST_OUT;
                        else
                            sub_reg <= sub_reg + 1'b1;
                    end
                end
                ST_OUT:
                begin
                    if (!in_item_reg)
                        st_reg <= ST_IDLE;
                    else if (out_load)
                    begin
                        in_item_reg <= 1'b0;
                        st_reg <= ST_IDLE;
                    end
                end
                default: st_reg <= ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
            out_reg <= {bas_reg[8], bas_reg[7], bas_reg[6], bas_reg[5], bas_reg[4],
                        bas_reg[3], bas_reg[2], bas_reg[1], bas_reg[0],
                        pos_reg[2], pos_reg[1], pos_reg[0]};
    end
endmodule
`default_nettype wire

/* rtl/core/efc_checker.sv */
`default_nettype none
`include "assert_macros.svh"
module efc_checker
(
    input wire         clk,
    input wire         rst_n,
    input wire         s_tvalid,
    input wire         s_tready,
    input wire         m_tvalid,
    input wire         m_tready,
    input wire [239:0] m_tdata
);
    // a result stays until its transfer
    `CHK_NEXT(a_out_hold, clk, rst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
    // after an input transfer no second item is taken next cycle
    `CHK_NEXT(a_one_item, clk, rst_n, s_tvalid && s_tready, !s_tready)
    // side_z is always zero
    `CHK_IMPLY(a_side_z, clk, rst_n, m_tvalid, m_tdata[191:176] == 16'd0)
    // front_z within unit range
    `CHK_IMPLY(a_front_z, clk, rst_n, m_tvalid,
        $signed(m_tdata[143:128]) <= 16'sd16384 && $signed(m_tdata[143:128]) >= -16'sd16384)
endmodule

bind euler_fly_camera_update_top efc_checker u_efc_checker (
    .clk(clk), .rst_n(rst_n), .s_tvalid(s_tvalid), .s_tready(s_tready),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
);
`default_nettype wire
